// File: hw/rtl/cs_pkg.sv
package cs_pkg;

  // Default sizes
  localparam int STACK_DEPTH_DEF   = 16;
  localparam int HISTORY_DEPTH_DEF = 8;

  // Fixed field widths
  localparam int COMMAND_W = 3;
  localparam int VALUE_W   = 32;
  localparam int STATUS_W  = 2;
  localparam int COUNT_W   = 5;

  typedef logic [COMMAND_W-1:0] command_t;
  typedef logic [STATUS_W-1:0]  status_t;
  typedef logic [VALUE_W-1:0]   value_t;

  // Command codes
  localparam command_t CMD_PUSH     = 3'd0;
  localparam command_t CMD_POP      = 3'd1;
  localparam command_t CMD_READ     = 3'd2;
  localparam command_t CMD_COMMIT   = 3'd3;
  localparam command_t CMD_ROLLBACK = 3'd4;
  localparam command_t CMD_CLEAR    = 3'd5;

  // Status codes
  localparam status_t ST_OK    = 2'd0;
  localparam status_t ST_EMPTY = 2'd1;
  localparam status_t ST_FULL  = 2'd2;

  // Index width for a store of the given depth, at least one bit
  function automatic int idx_w(input int depth);
    idx_w = (depth > 1) ? $clog2(depth) : 1;
  endfunction

  // Width of a counter that can hold the depth itself
  function automatic int cnt_w(input int depth);
    cnt_w = $clog2(depth + 1);
  endfunction

endpackage

// File: hw/rtl/cs_live_mem.sv
module cs_live_mem #(
  parameter int STACK_DEPTH = 16
) (
  input  logic                                      clk,
  input  logic                                      we,
  input  logic [cs_pkg::idx_w(STACK_DEPTH)-1:0]     waddr,
  input  cs_pkg::value_t                            wdata,
  input  logic [cs_pkg::idx_w(STACK_DEPTH)-1:0]     raddr,
  output cs_pkg::value_t                            rdata
);
  import cs_pkg::*;

  value_t mem [STACK_DEPTH];
  value_t rdata_r;

  // Write one word, read one word with a registered output
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

// File: hw/rtl/cs_hist_mem.sv
module cs_hist_mem #(
  parameter int STACK_DEPTH   = 16,
  parameter int HISTORY_DEPTH = 8
) (
  input  logic                                                          clk,
  input  logic                                                          ent_we,
  input  logic [cs_pkg::idx_w(HISTORY_DEPTH)+cs_pkg::idx_w(STACK_DEPTH)-1:0] ent_waddr,
  input  cs_pkg::value_t                                                ent_wdata,
  input  logic [cs_pkg::idx_w(HISTORY_DEPTH)+cs_pkg::idx_w(STACK_DEPTH)-1:0] ent_raddr,
  output cs_pkg::value_t                                                ent_rdata,
  input  logic                                                          cnt_we,
  input  logic [cs_pkg::idx_w(HISTORY_DEPTH)-1:0]                       cnt_waddr,
  input  logic [cs_pkg::cnt_w(STACK_DEPTH)-1:0]                         cnt_wdata,
  input  logic [cs_pkg::idx_w(HISTORY_DEPTH)-1:0]                       cnt_raddr,
  output logic [cs_pkg::cnt_w(STACK_DEPTH)-1:0]                         cnt_rdata
);
  import cs_pkg::*;

  localparam int IW        = idx_w(STACK_DEPTH);
  localparam int CW        = cnt_w(STACK_DEPTH);
  localparam int ENT_DEPTH = HISTORY_DEPTH * (2 ** IW);

  value_t          ent_mem [ENT_DEPTH];
  logic [CW-1:0]   cnt_mem [HISTORY_DEPTH];
  value_t          ent_rdata_r;
  logic [CW-1:0]   cnt_rdata_r;

  // Saved copies: one slot of 2**IW words per checkpoint
  always_ff @(posedge clk) begin
    if (ent_we) begin
      ent_mem[ent_waddr] <= ent_wdata;
    end
    ent_rdata_r <= ent_mem[ent_raddr];
  end

  // Entry count of each saved copy
  always_ff @(posedge clk) begin
    if (cnt_we) begin
      cnt_mem[cnt_waddr] <= cnt_wdata;
    end
    cnt_rdata_r <= cnt_mem[cnt_raddr];
  end

  assign ent_rdata = ent_rdata_r;
  assign cnt_rdata = cnt_rdata_r;

endmodule

// File: hw/rtl/cs_ctrl.sv
module cs_ctrl #(
  parameter int STACK_DEPTH   = 16,
  parameter int HISTORY_DEPTH = 8
) (
  input  logic                                                          clk,
  input  logic                                                          rst_n,
  input  logic                                                          start,
  output logic                                                          busy,
  input  cs_pkg::command_t                                              in_command,
  input  cs_pkg::value_t                                                in_push_value,
  // live stack memory
  output logic                                                          live_we,
  output logic [cs_pkg::idx_w(STACK_DEPTH)-1:0]                         live_waddr,
  output cs_pkg::value_t                                                live_wdata,
  output logic [cs_pkg::idx_w(STACK_DEPTH)-1:0]                         live_raddr,
  input  cs_pkg::value_t                                                live_rdata,
  // history memory
  output logic                                                          ent_we,
  output logic [cs_pkg::idx_w(HISTORY_DEPTH)+cs_pkg::idx_w(STACK_DEPTH)-1:0] ent_waddr,
  output cs_pkg::value_t                                                ent_wdata,
  output logic [cs_pkg::idx_w(HISTORY_DEPTH)+cs_pkg::idx_w(STACK_DEPTH)-1:0] ent_raddr,
  input  cs_pkg::value_t                                                ent_rdata,
  output logic                                                          cnt_we,
  output logic [cs_pkg::idx_w(HISTORY_DEPTH)-1:0]                       cnt_waddr,
  output logic [cs_pkg::cnt_w(STACK_DEPTH)-1:0]                         cnt_wdata,
  output logic [cs_pkg::idx_w(HISTORY_DEPTH)-1:0]                       cnt_raddr,
  input  logic [cs_pkg::cnt_w(STACK_DEPTH)-1:0]                         cnt_rdata,
  // result word
  output logic                                                          out_strobe,
  output cs_pkg::status_t                                               out_status,
  output cs_pkg::value_t                                                out_element,
  output logic                                                          out_element_valid,
  output logic [cs_pkg::COUNT_W-1:0]                                    out_element_count,
  output logic                                                          out_last
);
  import cs_pkg::*;

  localparam int IW  = idx_w(STACK_DEPTH);
  localparam int HW  = idx_w(HISTORY_DEPTH);
  localparam int CW  = cnt_w(STACK_DEPTH);
  localparam int LW  = cnt_w(HISTORY_DEPTH);
  localparam int CW1 = CW + 1;

  localparam logic [CW-1:0] FULL_COUNT = CW'(STACK_DEPTH);
  localparam logic [LW-1:0] FULL_LEVEL = LW'(HISTORY_DEPTH);

  localparam logic [2:0] S_IDLE    = 3'd0;
  localparam logic [2:0] S_READ    = 3'd1;
  localparam logic [2:0] S_COMMIT  = 3'd2;
  localparam logic [2:0] S_RB_CNT  = 3'd3;
  localparam logic [2:0] S_RB_COPY = 3'd4;

  logic [2:0]    state_r, state_nxt;
  logic [CW-1:0] count_r, count_nxt;
  logic [LW-1:0] level_r, level_nxt;
  logic [IW-1:0] idx_r, idx_nxt;
  logic [CW-1:0] n_r, n_nxt;

  logic          emit;
  status_t       st;
  value_t        elem;
  logic          elem_v;
  logic          last;

  logic          strobe_r;
  status_t       status_r;
  value_t        element_r;
  logic          element_valid_r;
  logic [COUNT_W-1:0] element_count_r;
  logic          last_r;

  logic [HW-1:0] slot;
  logic [HW-1:0] slot_m1;
  logic [IW-1:0] idx_inc;
  logic          at_top;
  logic          at_saved_top;

  assign slot         = level_r[HW-1:0];
  assign slot_m1      = HW'(level_r - 1'b1);
  assign idx_inc      = IW'(idx_r + 1'b1);
  assign at_top       = (CW1'(idx_r) + 1'b1) == CW1'(count_r);
  assign at_saved_top = (CW1'(idx_r) + 1'b1) == CW1'(n_r);
  assign busy         = (state_r != S_IDLE);

  // Decode the command and step through copies and reads
  always_comb begin
    state_nxt  = state_r;
    count_nxt  = count_r;
    level_nxt  = level_r;
    idx_nxt    = idx_r;
    n_nxt      = n_r;
    live_we    = 1'b0;
    live_waddr = idx_r;
    live_wdata = ent_rdata;
    live_raddr = idx_inc;
    ent_we     = 1'b0;
    ent_waddr  = {slot, idx_r};
    ent_wdata  = live_rdata;
    ent_raddr  = {slot_m1, idx_inc};
    cnt_we     = 1'b0;
    cnt_waddr  = slot;
    cnt_wdata  = count_r;
    cnt_raddr  = slot_m1;
    emit       = 1'b0;
    st         = ST_OK;
    elem       = '0;
    elem_v     = 1'b0;
    last       = 1'b1;

    case (state_r)
      S_IDLE: begin
        if (start) begin
          case (in_command)
            CMD_PUSH: begin
              emit = 1'b1;
              if (count_r == FULL_COUNT) begin
                st = ST_FULL;
              end else begin
                live_we    = 1'b1;
                live_waddr = count_r[IW-1:0];
                live_wdata = in_push_value;
                count_nxt  = CW'(count_r + 1'b1);
              end
            end
            CMD_POP: begin
              emit = 1'b1;
              if (count_r == '0) begin
                st = ST_EMPTY;
              end else begin
                count_nxt = CW'(count_r - 1'b1);
              end
            end
            CMD_READ: begin
              if (count_r == '0) begin
                emit = 1'b1;
              end else begin
                live_raddr = '0;
                idx_nxt    = '0;
                state_nxt  = S_READ;
              end
            end
            CMD_COMMIT: begin
              if (level_r == FULL_LEVEL) begin
                emit = 1'b1;
                st   = ST_FULL;
              end else begin
                cnt_we = 1'b1;
                if (count_r == '0) begin
                  emit      = 1'b1;
                  level_nxt = LW'(level_r + 1'b1);
                end else begin
                  live_raddr = '0;
                  idx_nxt    = '0;
                  state_nxt  = S_COMMIT;
                end
              end
            end
            CMD_ROLLBACK: begin
              if (level_r == '0) begin
                emit = 1'b1;
                st   = ST_EMPTY;
              end else begin
                state_nxt = S_RB_CNT;
              end
            end
            CMD_CLEAR: begin
              emit      = 1'b1;
              count_nxt = '0;
              level_nxt = '0;
            end
            default: begin
              emit = 1'b1;
            end
          endcase
        end
      end
      // stream one word per cycle, bottom first
      S_READ: begin
        emit   = 1'b1;
        elem   = live_rdata;
        elem_v = 1'b1;
        last   = at_top;
        if (at_top) begin
          state_nxt = S_IDLE;
        end else begin
          idx_nxt = idx_inc;
        end
      end
      // copy live words into the next history slot
      S_COMMIT: begin
        ent_we = 1'b1;
        if (at_top) begin
          emit      = 1'b1;
          level_nxt = LW'(level_r + 1'b1);
          state_nxt = S_IDLE;
        end else begin
          idx_nxt = idx_inc;
        end
      end
      // saved count is now on the read port
      S_RB_CNT: begin
        n_nxt   = cnt_rdata;
        idx_nxt = '0;
        if (cnt_rdata == '0) begin
          emit      = 1'b1;
          count_nxt = '0;
          level_nxt = LW'(level_r - 1'b1);
          state_nxt = S_IDLE;
        end else begin
          ent_raddr = {slot_m1, {IW{1'b0}}};
          state_nxt = S_RB_COPY;
        end
      end
      // copy saved words back into the live stack
      S_RB_COPY: begin
        live_we = 1'b1;
        if (at_saved_top) begin
          emit      = 1'b1;
          count_nxt = n_r;
          level_nxt = LW'(level_r - 1'b1);
          state_nxt = S_IDLE;
        end else begin
          idx_nxt = idx_inc;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // Control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_IDLE;
      count_r  <= '0;
      level_r  <= '0;
      strobe_r <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      count_r  <= count_nxt;
      level_r  <= level_nxt;
      strobe_r <= emit;
    end
  end

  // Working index and result word
  always_ff @(posedge clk) begin
    idx_r           <= idx_nxt;
    n_r             <= n_nxt;
    status_r        <= st;
    element_r       <= elem;
    element_valid_r <= elem_v;
    element_count_r <= COUNT_W'(count_nxt);
    last_r          <= last;
  end

  assign out_strobe        = strobe_r;
  assign out_status        = status_r;
  assign out_element       = element_r;
  assign out_element_valid = element_valid_r;
  assign out_element_count = element_count_r;
  assign out_last          = last_r;

endmodule

// File: hw/rtl/checkpointed_stack.sv
// Stack of signed 32-bit words with checkpoint and rollback.
// Command channel: present in_command and in_push_value with start high; the
// command is taken at a clock edge where start is high and busy is low.
// Result channel: each result word stands on the out_ ports for one cycle,
// marked by out_strobe; out_last flags the final word of a command. The
// receiver cannot stall, so results must be taken as they come.
// Per command, from the accepting edge:
//   push, pop, clear, read of an empty stack, unused codes, full/empty
//   refusals: result in the next cycle, busy stays low, one command per cycle.
//   read of n words: the first word passes the live memory read register and
//   the out_ registers, then one word per cycle; busy until the final word.
//   commit of n words: S_COMMIT copies them; busy until the result word.
//   rollback of n words: S_RB_CNT, then S_RB_COPY; busy until the result word.
// The copy rate is set by one read port per memory: each word moves from a
// registered read to a write in the other memory, one word per cycle.
// Reset (rst_n low, synchronous) empties the live stack and the history;
// memory contents are not cleared and need no clearing pass.
module checkpointed_stack #(
  parameter int STACK_DEPTH   = cs_pkg::STACK_DEPTH_DEF,
  parameter int HISTORY_DEPTH = cs_pkg::HISTORY_DEPTH_DEF
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        start,
  output logic                        busy,
  input  cs_pkg::command_t            in_command,
  input  cs_pkg::value_t              in_push_value,
  output logic                        out_strobe,
  output cs_pkg::status_t             out_status,
  output cs_pkg::value_t              out_element,
  output logic                        out_element_valid,
  output logic [cs_pkg::COUNT_W-1:0]  out_element_count,
  output logic                        out_last
);
  import cs_pkg::*;

  localparam int IW = idx_w(STACK_DEPTH);
  localparam int HW = idx_w(HISTORY_DEPTH);
  localparam int CW = cnt_w(STACK_DEPTH);

  logic              live_we;
  logic [IW-1:0]     live_waddr;
  value_t            live_wdata;
  logic [IW-1:0]     live_raddr;
  value_t            live_rdata;
  logic              ent_we;
  logic [HW+IW-1:0]  ent_waddr;
  value_t            ent_wdata;
  logic [HW+IW-1:0]  ent_raddr;
  value_t            ent_rdata;
  logic              cnt_we;
  logic [HW-1:0]     cnt_waddr;
  logic [CW-1:0]     cnt_wdata;
  logic [HW-1:0]     cnt_raddr;
  logic [CW-1:0]     cnt_rdata;

  cs_ctrl #(
    .STACK_DEPTH   (STACK_DEPTH),
    .HISTORY_DEPTH (HISTORY_DEPTH)
  ) u_ctrl (
    .clk               (clk),
    .rst_n             (rst_n),
    .start             (start),
    .busy              (busy),
    .in_command        (in_command),
    .in_push_value     (in_push_value),
    .live_we           (live_we),
    .live_waddr        (live_waddr),
    .live_wdata        (live_wdata),
    .live_raddr        (live_raddr),
    .live_rdata        (live_rdata),
    .ent_we            (ent_we),
    .ent_waddr         (ent_waddr),
    .ent_wdata         (ent_wdata),
    .ent_raddr         (ent_raddr),
    .ent_rdata         (ent_rdata),
    .cnt_we            (cnt_we),
    .cnt_waddr         (cnt_waddr),
    .cnt_wdata         (cnt_wdata),
    .cnt_raddr         (cnt_raddr),
    .cnt_rdata         (cnt_rdata),
    .out_strobe        (out_strobe),
    .out_status        (out_status),
    .out_element       (out_element),
    .out_element_valid (out_element_valid),
    .out_element_count (out_element_count),
    .out_last          (out_last)
  );

  cs_live_mem #(
    .STACK_DEPTH (STACK_DEPTH)
  ) u_live_mem (
    .clk   (clk),
    .we    (live_we),
    .waddr (live_waddr),
    .wdata (live_wdata),
    .raddr (live_raddr),
    .rdata (live_rdata)
  );

  cs_hist_mem #(
    .STACK_DEPTH   (STACK_DEPTH),
    .HISTORY_DEPTH (HISTORY_DEPTH)
  ) u_hist_mem (
    .clk       (clk),
    .ent_we    (ent_we),
    .ent_waddr (ent_waddr),
    .ent_wdata (ent_wdata),
    .ent_raddr (ent_raddr),
    .ent_rdata (ent_rdata),
    .cnt_we    (cnt_we),
    .cnt_waddr (cnt_waddr),
    .cnt_wdata (cnt_wdata),
    .cnt_raddr (cnt_raddr),
    .cnt_rdata (cnt_rdata)
  );

  // Push, pop and clear answer on the next cycle and leave the block free
  a_quick_cmd: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy && (in_command == CMD_PUSH || in_command == CMD_POP ||
                        in_command == CMD_CLEAR))
    |=> (out_strobe && out_last && !busy))
    else $error("single-cycle command did not answer in one cycle");

  // Words without an entry carry zero
  a_zero_elem: assert property (@(posedge clk) disable iff (!rst_n)
    (out_strobe && !out_element_valid) |-> (out_element == '0))
    else $error("element not zero on a word without an entry");

  // A refused command ends its result stream at once
  a_refusal_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_strobe && out_status != ST_OK) |-> (out_last && !out_element_valid))
    else $error("refusal word is not a single final word");

  // The final word of a command that kept the block busy frees it
  a_busy_end: assert property (@(posedge clk) disable iff (!rst_n)
    ($past(busy) && out_strobe && out_last) |-> !busy)
    else $error("block still busy after its final word");

endmodule

// File: tb/testbench.sv
`timescale 1ns / 1ps

module testbench;
  import cs_pkg::*;

  localparam int STACK_DEPTH   = STACK_DEPTH_DEF;
  localparam int HISTORY_DEPTH = HISTORY_DEPTH_DEF;
  localparam int IDLE_LIMIT    = 2000;
  localparam int TAIL_CYCLES   = 24;
  localparam int SEGMENT_LEN   = 30;

  // Unused command codes, expected to answer OK and change nothing
  localparam command_t CMD_SPARE_6 = 3'd6;
  localparam command_t CMD_SPARE_7 = 3'd7;

  typedef struct {
    status_t              status;
    value_t               element;
    logic                 element_valid;
    logic [COUNT_W-1:0]   element_count;
    logic                 last;
  } stack_word_t;

  // Tracks the live stack and the history, and checks each result word
  class stack_tracker;
    value_t      live_words[STACK_DEPTH];
    int          live_n;
    value_t      saved_words[HISTORY_DEPTH][STACK_DEPTH];
    int          saved_n[HISTORY_DEPTH];
    int          saved_level;
    stack_word_t pending_words[$];
    int          mismatches;

    function new();
      live_n      = 0;
      saved_level = 0;
      mismatches  = 0;
    endfunction

    function void add_word(status_t st, value_t elem, logic valid, logic is_last);
      stack_word_t w;
      w.status        = st;
      w.element       = elem;
      w.element_valid = valid;
      w.element_count = live_n[COUNT_W-1:0];
      w.last          = is_last;
      pending_words.insert(pending_words.size(), w);
    endfunction

    // Apply one accepted command and queue the words it must produce
    function void take_command(command_t cmd, value_t val);
      status_t st;
      int      slot;
      st = ST_OK;
      case (cmd)
        CMD_PUSH: begin
          if (live_n >= STACK_DEPTH) begin
            st = ST_FULL;
          end else begin
            live_words[live_n] = val;
            live_n++;
          end
        end
        CMD_POP: begin
          if (live_n == 0) st = ST_EMPTY;
          else live_n--;
        end
        CMD_READ: begin
          if (live_n == 0) begin
            add_word(ST_OK, '0, 1'b0, 1'b1);
          end else begin
            for (int i = 0; i < live_n; i++)
              add_word(ST_OK, live_words[i], 1'b1, i == live_n - 1);
          end
          return;
        end
        CMD_COMMIT: begin
          if (saved_level >= HISTORY_DEPTH) begin
            st = ST_FULL;
          end else begin
            for (int i = 0; i < live_n; i++)
              saved_words[saved_level][i] = live_words[i];
            saved_n[saved_level] = live_n;
            saved_level++;
          end
        end
        CMD_ROLLBACK: begin
          if (saved_level == 0) begin
            st = ST_EMPTY;
          end else begin
            slot = saved_level - 1;
            for (int i = 0; i < saved_n[slot]; i++)
              live_words[i] = saved_words[slot][i];
            live_n      = saved_n[slot];
            saved_level = slot;
          end
        end
        CMD_CLEAR: begin
          live_n      = 0;
          saved_level = 0;
        end
        default: ;
      endcase
      add_word(st, '0, 1'b0, 1'b1);
    endfunction

    // Compare one result word with the oldest expected word
    function void check_word(stack_word_t got);
      stack_word_t want;
      if (pending_words.size() == 0) begin
        $error("result word with none expected: element %0d, last %0b",
               $signed(got.element), got.last);
        mismatches++;
        return;
      end
      want = pending_words.pop_front();
      if (got.status !== want.status) begin
        $error("out_status: expected %0d, got %0d", want.status, got.status);
        mismatches++;
      end
      if (got.element !== want.element) begin
        $error("out_element: expected %0d, got %0d",
               $signed(want.element), $signed(got.element));
        mismatches++;
      end
      if (got.element_valid !== want.element_valid) begin
        $error("out_element_valid: expected %0b, got %0b",
               want.element_valid, got.element_valid);
        mismatches++;
      end
      if (got.element_count !== want.element_count) begin
        $error("out_element_count: expected %0d, got %0d",
               want.element_count, got.element_count);
        mismatches++;
      end
      if (got.last !== want.last) begin
        $error("out_last: expected %0b, got %0b", want.last, got.last);
        mismatches++;
      end
    endfunction

    function int outstanding();
      return pending_words.size();
    endfunction
  endclass

  logic                clk;
  logic                rst_n             = 1'b0;
  logic                start             = 1'b0;
  logic                busy;
  command_t            in_command        = CMD_PUSH;
  value_t              in_push_value     = '0;
  logic                out_strobe;
  status_t             out_status;
  value_t              out_element;
  logic                out_element_valid;
  logic [COUNT_W-1:0]  out_element_count;
  logic                out_last;

  stack_tracker tracker = new();
  int           idle_cycles = 0;

  checkpointed_stack i_dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .start             (start),
    .busy              (busy),
    .in_command        (in_command),
    .in_push_value     (in_push_value),
    .out_strobe        (out_strobe),
    .out_status        (out_status),
    .out_element       (out_element),
    .out_element_valid (out_element_valid),
    .out_element_count (out_element_count),
    .out_last          (out_last)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Note accepted commands and check result words at each edge
  always @(posedge clk) begin
    stack_word_t got;
    if (rst_n) begin
      if (out_strobe) begin
        got.status        = out_status;
        got.element       = out_element;
        got.element_valid = out_element_valid;
        got.element_count = out_element_count;
        got.last          = out_last;
        tracker.check_word(got);
      end
      if (start && !busy) tracker.take_command(in_command, in_push_value);
    end
  end

  // Abort when nothing moves for too long
  always @(posedge clk) begin
    if (!rst_n || (start && !busy) || out_strobe) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("Mismatches found");
        $finish;
      end
    end
  end

  // Random words half the time, else the extremes or small values
  function automatic value_t pick_value();
    case ($urandom_range(9))
      0:       return 32'h8000_0000;
      1:       return 32'h7fff_ffff;
      2:       return '0;
      3:       return '1;
      4:       return value_t'($urandom_range(15));
      default: return value_t'($urandom);
    endcase
  endfunction

  // Growing segments fill the stack and history, shrinking ones drain them
  function automatic command_t pick_command(bit grow);
    int r;
    r = $urandom_range(99);
    if (grow) begin
      if (r < 45) return CMD_PUSH;
      if (r < 53) return CMD_POP;
      if (r < 65) return CMD_READ;
      if (r < 87) return CMD_COMMIT;
      if (r < 95) return CMD_ROLLBACK;
      if (r < 97) return CMD_CLEAR;
    end else begin
      if (r < 15) return CMD_PUSH;
      if (r < 45) return CMD_POP;
      if (r < 57) return CMD_READ;
      if (r < 65) return CMD_COMMIT;
      if (r < 93) return CMD_ROLLBACK;
      if (r < 97) return CMD_CLEAR;
    end
    return $urandom_range(1) ? CMD_SPARE_7 : CMD_SPARE_6;
  endfunction

  // Present one command word, hold it until taken, then maybe idle
  task automatic send_command(command_t cmd, value_t val, int idle_pct);
    in_command    <= cmd;
    in_push_value <= val;
    start         <= 1'b1;
    @(posedge clk);
    while (busy) @(posedge clk);
    if ($urandom_range(99) < idle_pct) begin
      start         <= 1'b0;
      in_command    <= command_t'($urandom);
      in_push_value <= value_t'($urandom);
      do @(posedge clk); while ($urandom_range(99) < idle_pct);
    end
  endtask

  // Hold off until every expected word has arrived
  task automatic drain_results();
    start <= 1'b0;
    do @(negedge clk); while (tracker.outstanding() != 0);
    @(posedge clk);
  endtask

  int  idle_pct[3] = '{0, 59, 7};
  int  phase_items[3] = '{60, 85, 85};
  bit  grow;

  initial begin
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    // Directed: refusals on an empty block, extremes, every command
    send_command(CMD_ROLLBACK, '0, 0);
    send_command(CMD_POP, '0, 0);
    send_command(CMD_READ, '0, 0);
    send_command(CMD_PUSH, 32'h8000_0000, 0);
    send_command(CMD_PUSH, 32'h7fff_ffff, 0);
    send_command(CMD_PUSH, '0, 0);
    send_command(CMD_READ, '0, 0);
    send_command(CMD_COMMIT, '0, 0);
    send_command(CMD_POP, '1, 0);
    send_command(CMD_ROLLBACK, '0, 0);
    send_command(CMD_READ, '0, 0);
    send_command(CMD_SPARE_6, '1, 0);
    send_command(CMD_SPARE_7, 32'h5a5a_a5a5, 0);
    send_command(CMD_CLEAR, '0, 0);
    send_command(CMD_READ, '0, 0);
    drain_results();

    for (int p = 0; p < 3; p++) begin
      // Fill the stack and the history past their limits
      if (p == 0) begin
        repeat (STACK_DEPTH + 1) send_command(CMD_PUSH, pick_value(), idle_pct[p]);
        repeat (HISTORY_DEPTH + 1) send_command(CMD_COMMIT, pick_value(), idle_pct[p]);
      end
      for (int n = 0; n < phase_items[p]; n++) begin
        if (n % SEGMENT_LEN == 0) grow = $urandom_range(1);
        send_command(pick_command(grow), pick_value(), idle_pct[p]);
      end
      drain_results();
    end

    repeat (TAIL_CYCLES) @(posedge clk);
    if (tracker.outstanding() != 0) begin
      $error("%0d result words never arrived", tracker.outstanding());
      tracker.mismatches++;
    end
    if (tracker.mismatches == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

// File: sim.f
hw/rtl/cs_pkg.sv
hw/rtl/cs_live_mem.sv
hw/rtl/cs_hist_mem.sv
hw/rtl/cs_ctrl.sv
hw/rtl/checkpointed_stack.sv
tb/testbench.sv
